@@ src/itrb_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the interrupt and timer register block
// no dependencies

package itrb_pkg;

    localparam int DATA_W = 64;
    localparam int OFF_W  = 10;
    localparam int IDX_W  = 7;

    // item commands
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_ASSERT   = 3'd2;
    localparam logic [2:0] CMD_DEASSERT = 3'd3;
    localparam logic [2:0] CMD_TICK     = 3'd4;

    // irq edge codes
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HAS_GRAPHICS    = 2'd0;
    localparam logic [1:0] CFG_LARGE_BANKS     = 2'd1;
    localparam logic [1:0] CFG_BANKS_POPULATED = 2'd2;
    localparam logic [1:0] CFG_TIME_PER_TICK   = 2'd3;

    // word indexes
    localparam logic [IDX_W-1:0] W_REV   = 7'd0;
    localparam logic [IDX_W-1:0] W_CTRL  = 7'd1;
    localparam logic [IDX_W-1:0] W_STAT  = 7'd2;
    localparam logic [IDX_W-1:0] W_MASK  = 7'd3;
    localparam logic [IDX_W-1:0] W_SOFT  = 7'd4;
    localparam logic [IDX_W-1:0] W_HARD  = 7'd5;
    localparam logic [IDX_W-1:0] W_TIME  = 7'd7;
    localparam logic [IDX_W-1:0] W_BANK0 = 7'd65;

    // exact byte offsets with side effects
    localparam logic [OFF_W-1:0] OFF_CTRL = 10'h008;
    localparam logic [OFF_W-1:0] OFF_STAT = 10'h010;
    localparam logic [OFF_W-1:0] OFF_MASK = 10'h018;

    localparam logic [DATA_W-1:0] CTRL_ENDIAN   = 64'h100;
    localparam logic [DATA_W-1:0] BANK_BIG_FLAG = 64'h100;
    localparam int                HARD_RST_BIT  = 11;
    localparam logic [7:0]        REV_GFX       = 8'ha1;
    localparam logic [7:0]        REV_BASE      = 8'h11;
    localparam logic [3:0]        POP_RESET     = 4'd4;
    localparam logic [7:0]        TPT_RESET     = 8'd66;

    typedef struct packed {
        logic accept;   // item transfer this cycle, capture and read word memory
        logic commit;   // update state and load the output register
    } t_dp_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

@@ src/itrb_ctrl.sv @@
`timescale 1ns / 1ps
// controller: item sequencing and output register valid flag
// depends on itrb_pkg

module itrb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output itrb_pkg::t_dp_cmd o_dp_cmd
);
    import itrb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, commit;

    always_comb begin
        accept      = i_in_valid && (r_state == S_IDLE);
        commit      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here while an older result is still unclaimed
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_dp_cmd.accept = accept;
    assign o_dp_cmd.commit = commit;

endmodule

@@ src/itrb_datapath.sv @@
`timescale 1ns / 1ps
// datapath: config registers, interrupt and timer words, word memory, result register
// depends on itrb_pkg

module itrb_datapath #(
    parameter int REGISTER_COUNT = 80,
    parameter int LINE_COUNT     = 32,
    parameter int BANK_COUNT     = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itrb_pkg::t_dp_cmd i_dp_cmd,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic [2:0]        i_cmd,
    input  logic [9:0]        i_byte_offset,
    input  logic              i_wide_access,
    input  logic [63:0]       i_write_value,
    input  logic [4:0]        i_line_number,
    input  logic [15:0]       i_elapsed_us,
    output logic [63:0]       o_read_value,
    output logic              o_irq_level,
    output logic [1:0]        o_irq_edge,
    output logic              o_reset_request
);
    import itrb_pkg::*;

    localparam int         AW       = $clog2(REGISTER_COUNT);
    localparam logic [7:0] RC_LIM   = 8'(REGISTER_COUNT);
    localparam logic [7:0] BANK_END = 8'(65 + BANK_COUNT);

    function automatic logic [DATA_W-1:0] bank_word(input logic big, input logic [2:0] b);
        logic [DATA_W-1:0] v;
        v = big ? (BANK_BIG_FLAG | {59'd0, b, 2'b00}) : {61'd0, b};
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // configuration
    logic                  r_has_graphics;
    logic                  r_large_banks;
    logic [3:0]            r_banks_pop;
    logic [7:0]            r_time_per_tick;

    // architectural words kept in flops
    logic [DATA_W-1:0]     r_mask, n_mask;
    logic [DATA_W-1:0]     r_soft, n_soft;
    logic [DATA_W-1:0]     r_time, n_time;
    logic [DATA_W-1:0]     r_bank0, n_bank0;
    logic [LINE_COUNT-1:0] r_hw, n_hw;
    logic                  r_irq_prev, n_irq_prev;

    // general words
    logic [DATA_W-1:0]         r_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_mem_vld;
    logic [DATA_W-1:0]         r_mem_rdata;
    logic                      r_mem_rvld;

    // captured item
    logic [2:0]        r_op;
    logic [OFF_W-1:0]  r_off;
    logic              r_wide;
    logic [DATA_W-1:0] r_wval;
    logic [4:0]        r_line;
    logic [23:0]       r_add;

    // result register
    logic [DATA_W-1:0] r_read_value;
    logic              r_irq_level;
    logic [1:0]        r_irq_edge;
    logic              r_reset_request;

    logic [IDX_W-1:0]      in_idx;
    logic                  in_rng_in;
    logic [IDX_W-1:0]      idx;
    logic                  low_half;
    logic                  in_rng;
    logic                  is_bank;
    logic [2:0]            bank;
    logic                  is_bus;
    logic                  do_wr;
    logic                  mem_word;
    logic                  mem_we;
    logic [DATA_W-1:0]     bank0_forced;
    logic [DATA_W-1:0]     bank_cur;
    logic [DATA_W-1:0]     cur;
    logic [DATA_W-1:0]     merged;
    logic [DATA_W-1:0]     rd_val;
    logic [LINE_COUNT-1:0] line_mask;
    logic                  eval;
    logic                  level;
    logic [1:0]            edge_code;
    logic                  rst_req;

    assign in_idx    = i_byte_offset[OFF_W-1:3];
    assign in_rng_in = {1'b0, in_idx} < RC_LIM;

    always_comb begin
        idx      = r_off[OFF_W-1:3];
        low_half = r_off[2];
        in_rng   = {1'b0, idx} < RC_LIM;
        is_bank  = (idx >= W_BANK0) && ({1'b0, idx} < BANK_END);
        bank     = 3'(idx - W_BANK0);
        is_bus   = (r_op == CMD_READ) || (r_op == CMD_WRITE);
        do_wr    = (r_op == CMD_WRITE) && in_rng;

        // bank words are rebuilt from config on every bus access unless no banks are populated
        bank0_forced = (r_banks_pop == 4'd0) ? r_bank0 : bank_word(r_large_banks, 3'd0);
        if (r_banks_pop == 4'd0) begin
            bank_cur = r_bank0;
        end else if ({1'b0, bank} < r_banks_pop) begin
            bank_cur = bank_word(r_large_banks, bank);
        end else begin
            bank_cur = bank_word(r_large_banks, 3'd0);
        end

        mem_word = 1'b0;
        cur      = '0;
        if (in_rng) begin
            case (idx)
                W_REV:  cur = {56'd0, r_has_graphics ? REV_GFX : REV_BASE};
                W_CTRL: cur = CTRL_ENDIAN;
                W_STAT: cur = r_soft | DATA_W'(r_hw);
                W_MASK: cur = r_mask;
                W_SOFT: cur = r_soft;
                W_HARD: cur = DATA_W'(r_hw);
                W_TIME: cur = r_time;
                default: begin
                    if (is_bank) begin
                        cur = bank_cur;
                    end else begin
                        mem_word = 1'b1;
                        cur      = r_mem_rvld ? r_mem_rdata : '0;
                    end
                end
            endcase
        end

        if (r_wide) begin
            merged = r_wval;
        end else if (low_half) begin
            merged = {cur[63:32], r_wval[31:0]};
        end else begin
            merged = {r_wval[31:0], cur[31:0]};
        end

        rd_val = '0;
        if (r_op == CMD_READ) begin
            if (r_wide) begin
                rd_val = cur;
            end else begin
                rd_val = low_half ? sext32(cur[31:0]) : sext32(cur[63:32]);
            end
        end

        mem_we = i_dp_cmd.commit && do_wr && mem_word;

        n_mask = (do_wr && idx == W_MASK) ? merged : r_mask;
        n_soft = (do_wr && idx == W_SOFT) ? merged : r_soft;

        n_time = r_time;
        if (do_wr && idx == W_TIME) begin
            n_time = merged;
        end else if (r_op == CMD_TICK && r_add != 24'd0) begin
            n_time = {32'd0, r_time[31:0] + 32'(r_add)};
        end

        n_bank0 = r_bank0;
        if (is_bus) begin
            n_bank0 = (do_wr && idx == W_BANK0) ? merged : bank0_forced;
        end

        // lines at or above the line count decode to an empty mask
        for (int i = 0; i < LINE_COUNT; i++) begin
            line_mask[i] = (r_line == 5'(i));
        end
        n_hw = r_hw;
        if (r_op == CMD_ASSERT) begin
            n_hw = r_hw | line_mask;
        end else if (r_op == CMD_DEASSERT) begin
            n_hw = r_hw & ~line_mask;
        end

        eval = (is_bus && (r_off == OFF_STAT || r_off == OFF_MASK))
            || (r_op == CMD_ASSERT) || (r_op == CMD_DEASSERT) || (r_op == CMD_TICK);
        level = |((n_soft | DATA_W'(n_hw)) & n_mask);

        edge_code  = EDGE_NONE;
        n_irq_prev = r_irq_prev;
        if (eval) begin
            n_irq_prev = level;
            if (level && !r_irq_prev) begin
                edge_code = EDGE_RISE;
            end else if (!level && r_irq_prev) begin
                edge_code = EDGE_FALL;
            end
        end

        rst_req = (r_op == CMD_WRITE) && (r_off == OFF_CTRL) && r_wval[HARD_RST_BIT];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_graphics  <= 1'b0;
            r_large_banks   <= 1'b0;
            r_banks_pop     <= POP_RESET;
            r_time_per_tick <= TPT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HAS_GRAPHICS:    r_has_graphics  <= i_cfg_data[0];
                CFG_LARGE_BANKS:     r_large_banks   <= i_cfg_data[0];
                CFG_BANKS_POPULATED: r_banks_pop     <= i_cfg_data[3:0];
                CFG_TIME_PER_TICK:   r_time_per_tick <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_soft     <= '0;
            r_time     <= '0;
            r_bank0    <= '0;
            r_hw       <= '0;
            r_irq_prev <= 1'b0;
            r_mem_vld  <= '0;
        end else if (i_dp_cmd.commit) begin
            r_mask     <= n_mask;
            r_soft     <= n_soft;
            r_time     <= n_time;
            r_bank0    <= n_bank0;
            r_hw       <= n_hw;
            r_irq_prev <= n_irq_prev;
            if (mem_we) begin
                r_mem_vld[idx[AW-1:0]] <= 1'b1;
            end
        end
    end

    // word memory, registered read at item transfer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[idx[AW-1:0]] <= merged;
        end
        if (i_dp_cmd.accept && in_rng_in) begin
            r_mem_rdata <= r_mem[in_idx[AW-1:0]];
            r_mem_rvld  <= r_mem_vld[in_idx[AW-1:0]];
        end
    end

    // item capture; the tick product is formed here so the update only adds
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) begin
            r_op   <= i_cmd;
            r_off  <= i_byte_offset;
            r_wide <= i_wide_access;
            r_wval <= i_write_value;
            r_line <= i_line_number;
            r_add  <= 24'(i_elapsed_us) * 24'(r_time_per_tick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit) begin
            r_read_value    <= rd_val;
            r_irq_level     <= n_irq_prev;
            r_irq_edge      <= edge_code;
            r_reset_request <= rst_req;
        end
    end

    assign o_read_value    = r_read_value;
    assign o_irq_level     = r_irq_level;
    assign o_irq_edge      = r_irq_edge;
    assign o_reset_request = r_reset_request;

endmodule

@@ src/interrupt_timer_register_block_core.sv @@
`timescale 1ns / 1ps
// top level of the interrupt and timer register block
// depends on itrb_pkg, itrb_ctrl, itrb_datapath

// Each item (bus read or write, line assert or deassert, time tick) is handled
// in turn: the transfer cycle registers the item and reads the general word
// memory through its single registered read port, and the execute state
// forms the read-modify-write, updates the words and loads the output register
// when it is free. No new item is taken until the last one has loaded it; the
// output register lets the next item be transferred while a result waits.
// Word memory, interrupt words and irq state come up cleared out of reset
// with no clearing pass. Configuration writes are taken every cycle.

module interrupt_timer_register_block_core #(
    parameter int REGISTER_COUNT = 80,
    parameter int LINE_COUNT     = 32,
    parameter int BANK_COUNT     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_byte_offset,
    input  logic        i_wide_access,
    input  logic [63:0] i_write_value,
    input  logic [4:0]  i_line_number,
    input  logic [15:0] i_elapsed_us,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_read_value,
    output logic        o_irq_level,
    output logic [1:0]  o_irq_edge,
    output logic        o_reset_request,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import itrb_pkg::*;

    t_dp_cmd dp_cmd;

    assign o_cfg_ready = 1'b1;

    itrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (dp_cmd)
    );

    itrb_datapath #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .LINE_COUNT     (LINE_COUNT),
        .BANK_COUNT     (BANK_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_byte_offset   (i_byte_offset),
        .i_wide_access   (i_wide_access),
        .i_write_value   (i_write_value),
        .i_line_number   (i_line_number),
        .i_elapsed_us    (i_elapsed_us),
        .o_read_value    (o_read_value),
        .o_irq_level     (o_irq_level),
        .o_irq_edge      (o_irq_edge),
        .o_reset_request (o_reset_request)
    );

endmodule

@@ src/itrb_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the interrupt and timer register block, bound to the top level
// depends on itrb_pkg and interrupt_timer_register_block_core

module itrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_read_value,
    input logic        o_irq_level,
    input logic [1:0]  o_irq_edge,
    input logic        o_reset_request
);
    import itrb_pkg::*;

    // edge code agrees with the level reported next to it
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq_edge == EDGE_RISE |-> o_irq_level)
        else $error("rising irq edge reported with low level");

    a_fall_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_irq_edge == EDGE_FALL || o_irq_edge == EDGE_RISE
            || o_irq_edge == EDGE_NONE) && o_irq_edge == EDGE_FALL |-> !o_irq_level)
        else $error("falling irq edge reported with high level");

    // a reset request only comes from a write, which returns no read data
    a_rst_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_request |-> o_read_value == 64'd0)
        else $error("reset request with nonzero read data");

    // one item in flight: ready drops after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_irq_edge))
        else $error("stalled result changed");

endmodule

bind interrupt_timer_register_block_core itrb_checker u_itrb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_read_value    (o_read_value),
    .o_irq_level     (o_irq_level),
    .o_irq_edge      (o_irq_edge),
    .o_reset_request (o_reset_request)
);
